[design/sobol_sequence_generator_defines.svh]
// ----------------------------------------------------------------------------
// Sobol sequence generator assertion macros
// Shared concurrent assertion shorthands, clocked on clock and muted in reset.
// ----------------------------------------------------------------------------
`ifndef SOBOL_SEQUENCE_GENERATOR_DEFINES_SVH
`define SOBOL_SEQUENCE_GENERATOR_DEFINES_SVH

// Same-cycle property check.
`define SOBOL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle implies a property in the next.
`define SOBOL_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/sobol_pkg.sv]
// ----------------------------------------------------------------------------
// Sobol sequence generator package
// Shared constants, codes, the cell command type and the Gray-code helper.
// ----------------------------------------------------------------------------
package sobol_pkg;

   localparam int MAX_DIMS_DEF = 16;
   localparam int MAX_BITS_DEF = 32;

   localparam int WORD_W    = 32;
   localparam int DIM_W     = 4;
   localparam int BITPOS_W  = 6;
   localparam int BITIDX_W  = 5;
   localparam int DIMS_W    = 5;
   localparam int BITS_W    = 6;
   localparam int REQ_TDATA_W = 80;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic REG_DIMS_USED = 1'b0;
   localparam logic REG_BITS_USED = 1'b1;

   localparam logic [DIMS_W-1:0] DIMS_USED_RST = 5'd16;
   localparam logic [BITS_W-1:0] BITS_USED_RST = 6'd32;

   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic                xor_en;
      logic                clear;
      logic [DIM_W-1:0]    dim;
      logic [BITIDX_W-1:0] addr;
      logic [WORD_W-1:0]   data;
      logic [DIMS_W-1:0]   dims;
   } cell_cmd_type;

   function automatic logic [WORD_W-1:0] gray(input logic [WORD_W-1:0] x);
      return x ^ (x >> 1);
   endfunction

endpackage

[design/sobol_cell.sv]
// ----------------------------------------------------------------------------
// Sobol dimension cell
// Holds the direction words and the running XOR word of one dimension and
// passes the selected word along the readout chain.
// ----------------------------------------------------------------------------
module sobol_cell #(
   parameter int CELL_IDX = 0,
   parameter int MAX_BITS = sobol_pkg::MAX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sobol_pkg::cell_cmd_type       cmd,
   input  logic [sobol_pkg::WORD_W-1:0]  chain_in,
   output logic [sobol_pkg::WORD_W-1:0]  chain_out
);

   localparam int AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

   logic [sobol_pkg::WORD_W-1:0] dir_mem [MAX_BITS];
   logic [sobol_pkg::WORD_W-1:0] rd_ff;
   logic [sobol_pkg::WORD_W-1:0] word_ff;
   logic [sobol_pkg::WORD_W-1:0] word_in;
   logic [sobol_pkg::WORD_W-1:0] word_view;
   logic [AW-1:0]                addr;
   logic                         sel;
   logic                         active;

   assign addr   = cmd.addr[AW-1:0];
   assign sel    = (int'(cmd.dim) == CELL_IDX);
   assign active = (int'(cmd.dims) > CELL_IDX) || ((cmd.dims == '0) && (CELL_IDX == 0));

   always_ff @(posedge clock) begin
      if (cmd.wr_en && sel) begin
         dir_mem[addr] <= cmd.data;
      end
      if (cmd.rd_en) begin
         rd_ff <= dir_mem[addr];
      end
   end

   assign word_view = (cmd.xor_en && active) ? (word_ff ^ rd_ff) : word_ff;

   always_comb begin
      if (cmd.clear) begin
         word_in = '0;
      end else begin
         word_in = word_view;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign chain_out = sel ? word_view : chain_in;

endmodule

[design/sobol_ctrl.sv]
// ----------------------------------------------------------------------------
// Sobol sequence controller
// Accepts requests, tracks the current point, walks the Gray-code step mask
// one direction bit per cycle and holds the response register.
// ----------------------------------------------------------------------------
`include "sobol_sequence_generator_defines.svh"

module sobol_ctrl #(
   parameter int MAX_BITS = sobol_pkg::MAX_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_type,
   input  logic [sobol_pkg::DIM_W-1:0]     req_dim,
   input  logic [sobol_pkg::BITPOS_W-1:0]  req_bit_pos,
   input  logic [sobol_pkg::WORD_W-1:0]    req_dir_word,
   input  logic [sobol_pkg::WORD_W-1:0]    req_point_index,
   input  logic [sobol_pkg::DIMS_W-1:0]    dims_used,
   input  logic [sobol_pkg::BITS_W-1:0]    bits_used,
   output sobol_pkg::cell_cmd_type         cmd,
   input  logic [sobol_pkg::WORD_W-1:0]    chain_word,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sobol_pkg::WORD_W-1:0]    rsp_sample_value,
   output logic                            rsp_status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                            state_ff, state_in;
   logic [sobol_pkg::WORD_W-1:0]    cur_ff, cur_in;
   logic [MAX_BITS-1:0]             mask_ff, mask_in;
   logic                            xor_en_ff, xor_en_in;
   logic                            err_ff, err_in;
   logic [sobol_pkg::DIM_W-1:0]     dim_ff, dim_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sobol_pkg::WORD_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   logic                            accept;
   logic                            accept_sample;
   logic                            accept_ok;
   logic                            too_large;
   logic                            backward;
   logic [sobol_pkg::BITS_W-1:0]    eff_bits;
   logic [sobol_pkg::WORD_W-1:0]    mask_full;
   logic [MAX_BITS-1:0]             scan_src;
   logic [MAX_BITS-1:0]             low_oh;
   logic [sobol_pkg::BITIDX_W-1:0]  enc_addr;
   logic [sobol_pkg::BITPOS_W-1:0]  load_pos;
   logic                            load_ok;
   logic                            issue;
   logic                            done;
   logic                            rsp_load;

   assign req_tready    = (state_ff == ST_IDLE);
   assign accept        = req_tvalid && req_tready;
   assign accept_sample = accept && (req_type == sobol_pkg::REQ_SAMPLE);

   always_comb begin
      if (bits_used == '0) begin
         eff_bits = 6'd1;
      end else if (int'(bits_used) > MAX_BITS) begin
         eff_bits = 6'(MAX_BITS);
      end else begin
         eff_bits = bits_used;
      end
   end

   assign too_large = ((req_point_index >> eff_bits) != '0);
   assign accept_ok = accept_sample && !too_large;
   assign backward  = (req_point_index < cur_ff);
   assign mask_full = backward ? sobol_pkg::gray(req_point_index)
                               : (sobol_pkg::gray(cur_ff) ^ sobol_pkg::gray(req_point_index));

   assign scan_src = (state_ff == ST_IDLE) ? mask_full[MAX_BITS-1:0] : mask_ff;
   assign low_oh   = scan_src & (~scan_src + 1'b1);

   always_comb begin
      enc_addr = '0;
      for (int b = 0; b < MAX_BITS; b++) begin
         if (low_oh[b]) begin
            enc_addr = enc_addr | sobol_pkg::BITIDX_W'(b);
         end
      end
   end

   assign issue = (state_ff == ST_RUN) ? (mask_ff != '0) : (accept_ok && (scan_src != '0));
   assign done  = (state_ff == ST_RUN) && (mask_ff == '0);
   assign rsp_load = done && (!rsp_valid_ff || rsp_tready);

   assign load_pos = req_bit_pos - 6'd1;
   assign load_ok  = accept && (req_type == sobol_pkg::REQ_LOAD) && (req_bit_pos != '0)
                     && (int'(req_bit_pos) <= MAX_BITS);

   always_comb begin
      cmd.wr_en  = load_ok;
      cmd.rd_en  = issue;
      cmd.xor_en = xor_en_ff;
      cmd.clear  = accept_ok && backward;
      cmd.dim    = (state_ff == ST_IDLE) ? req_dim : dim_ff;
      cmd.addr   = load_ok ? load_pos[sobol_pkg::BITIDX_W-1:0] : enc_addr;
      cmd.data   = req_dir_word;
      cmd.dims   = dims_used;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      mask_in      = mask_ff;
      err_in       = err_ff;
      dim_in       = dim_ff;
      xor_en_in    = issue;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept_ok || ((state_ff == ST_RUN) && (mask_ff != '0))) begin
         mask_in = scan_src & (scan_src - 1'b1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_sample) begin
               state_in = ST_RUN;
               err_in   = too_large;
               dim_in   = req_dim;
               if (too_large) begin
                  mask_in = '0;
               end else begin
                  cur_in = req_point_index;
               end
            end
         end
         ST_RUN: begin
            if (rsp_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = err_ff ? '0 : chain_word;
               rsp_user_in  = err_ff ? sobol_pkg::STATUS_RANGE : sobol_pkg::STATUS_OK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         mask_ff      <= '0;
         xor_en_ff    <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         mask_ff      <= mask_in;
         xor_en_ff    <= xor_en_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dim_ff      <= dim_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_sample_value = rsp_data_ff;
   assign rsp_status       = rsp_user_ff;

   `SOBOL_ASSERT(a_idle_no_xor, (state_ff == ST_IDLE) |-> !xor_en_ff, "XOR pending while idle")
   `SOBOL_ASSERT(a_err_no_step, (state_ff == ST_RUN && err_ff) |-> (mask_ff == '0 && !xor_en_ff), "Out-of-range request is stepping")
   `SOBOL_ASSERT_NEXT(a_mask_shrinks, state_ff == ST_RUN && mask_ff != '0, $countones(mask_ff) + 1 == $countones($past(mask_ff)), "Step mask did not lose exactly one bit")

endmodule

[design/sobol_sequence_generator.sv]
// ----------------------------------------------------------------------------
// Sobol sequence generator
// Gray-code Sobol point generator built as a row of per-dimension cells.
// ----------------------------------------------------------------------------
// The host first writes direction words with load requests (tuser low), one
// word per dimension and bit position, then issues sample requests (tuser
// high) that carry a point index and a dimension. Each sample request gives
// one response: the dimension's coordinate as a 0.32 fraction in tdata and a
// range flag in tuser. Load requests give no response and leave the
// controller ready for the next request. A sample request walks the
// Gray-code step mask: the difference from the current point, or from point
// zero on a backward request, which replays from there. The walk reads one
// direction bit per cycle; the result then goes to the response register,
// and the next request is accepted only after that, when the controller
// has returned to its idle state and raises req_tready again.
// dims_used and bits_used sit at byte addresses 0 and 4 of the register port.
// Reset clears the running words and the point and sets 16 dimensions and 32
// bits; direction words are undefined until loaded. A stalled response waits
// in the output register; the next request is accepted, walked, then waits.
// ----------------------------------------------------------------------------
module sobol_sequence_generator #(
   parameter int MAX_DIMS = sobol_pkg::MAX_DIMS_DEF,
   parameter int MAX_BITS = sobol_pkg::MAX_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // dim [3:0], bit_pos [9:4], dir_word [41:10], point_index [73:42], zeros.
   input  logic [sobol_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type [0].
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // sample_value [31:0].
   output logic [sobol_pkg::WORD_W-1:0]        rsp_tdata,
   // status [0].
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sobol_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sobol_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sobol_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   logic [sobol_pkg::DIMS_W-1:0] dims_used_ff, dims_used_in;
   logic [sobol_pkg::BITS_W-1:0] bits_used_ff, bits_used_in;
   logic                         csr_write;
   sobol_pkg::cell_cmd_type      cmd;
   logic [sobol_pkg::WORD_W-1:0] chain [MAX_DIMS+1];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      dims_used_in = dims_used_ff;
      bits_used_in = bits_used_ff;
      csr_prdata   = '0;
      unique case (csr_paddr[2])
         sobol_pkg::REG_DIMS_USED: begin
            csr_prdata = {{(sobol_pkg::CSR_DATA_W-sobol_pkg::DIMS_W){1'b0}}, dims_used_ff};
            if (csr_write) begin
               dims_used_in = csr_pwdata[sobol_pkg::DIMS_W-1:0];
            end
         end
         sobol_pkg::REG_BITS_USED: begin
            csr_prdata = {{(sobol_pkg::CSR_DATA_W-sobol_pkg::BITS_W){1'b0}}, bits_used_ff};
            if (csr_write) begin
               bits_used_in = csr_pwdata[sobol_pkg::BITS_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_used_ff <= sobol_pkg::DIMS_USED_RST;
         bits_used_ff <= sobol_pkg::BITS_USED_RST;
      end else begin
         dims_used_ff <= dims_used_in;
         bits_used_ff <= bits_used_in;
      end
   end

   sobol_ctrl #(
      .MAX_BITS (MAX_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_type         (req_tuser),
      .req_dim          (req_tdata[3:0]),
      .req_bit_pos      (req_tdata[9:4]),
      .req_dir_word     (req_tdata[41:10]),
      .req_point_index  (req_tdata[73:42]),
      .dims_used        (dims_used_ff),
      .bits_used        (bits_used_ff),
      .cmd              (cmd),
      .chain_word       (chain[MAX_DIMS]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_sample_value (rsp_tdata),
      .rsp_status       (rsp_tuser)
   );

   assign chain[0] = '0;

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
      sobol_cell #(
         .CELL_IDX (d),
         .MAX_BITS (MAX_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[d]),
         .chain_out (chain[d+1])
      );
   end

endmodule
